// ===== sv/hdrtm_pkg.sv =====
// Shared types, constants and the gamma table for the HDR tone mapping pipeline.
// No dependencies; used by every module of the block.
package hdrtm_pkg;

  localparam int unsigned IN_W         = 24;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned IN_FRAC_BITS = 16;
  localparam int unsigned T_W          = 16;
  localparam int unsigned GTB          = 10;
  localparam int unsigned TAB_SIZE     = (1 << GTB) + 1;
  localparam int unsigned TAB_AW       = GTB + 1;
  localparam int unsigned FRAC_S       = T_W - GTB;
  localparam int unsigned Y_W          = 17;
  localparam int unsigned DEN_W        = IN_W + 1;
  localparam int unsigned DIV_STEPS    = 4;
  localparam int unsigned DIV_STAGES   = T_W / DIV_STEPS;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);
  localparam int unsigned SCALE_MUL    = 2559;
  localparam int unsigned SCALE_SH     = 17;
  localparam int unsigned DIV5_MUL     = 52429;
  localparam int unsigned DIV5_SH      = 18;
  localparam int unsigned LATENCY      = 6 + DIV_STAGES;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [T_W-1:0]   quo;
  } div_t;

  typedef logic [Y_W-1:0] gtab_t [TAB_SIZE];

  // Largest y with y^11 <= i^5 * 2^(176 - 5*GTB), i.e. 2^16 * (i/2^GTB)^(5/11).
  function automatic logic [Y_W-1:0] gamma_entry(int unsigned i);
    logic [191:0] target;
    logic [191:0] pw;
    logic [Y_W-1:0] lo;
    logic [Y_W-1:0] hi;
    logic [Y_W-1:0] mid;
    target = 192'(i);
    target = target * 192'(i) * 192'(i) * 192'(i) * 192'(i);
    target = target << (176 - 5 * GTB);
    lo = '0;
    hi = Y_W'(65536);
    while (lo < hi) begin
      mid = lo + ((hi - lo + Y_W'(1)) >> 1);
      pw = 192'(1);
      for (int n = 0; n < 11; n++) begin
        pw = pw * 192'(mid);
      end
      if (pw <= target) begin
        lo = mid;
      end else begin
        hi = mid - Y_W'(1);
      end
    end
    return lo;
  endfunction

  function automatic gtab_t build_gamma_tab();
    gtab_t tab;
    for (int unsigned i = 0; i < TAB_SIZE; i++) begin
      tab[i] = gamma_entry(i);
    end
    return tab;
  endfunction

  localparam gtab_t GAMMA_TAB = build_gamma_tab();

endpackage

// ===== sv/hdrtm_div_stage.sv =====
// One register stage of the restoring divider: DIV_STEPS quotient bits per stage.
// Depends on hdrtm_pkg.
module hdrtm_div_stage (
  input  logic              clk,
  input  hdrtm_pkg::div_t   div_in,
  output hdrtm_pkg::div_t   div_out
);

  hdrtm_pkg::div_t div_r;
  hdrtm_pkg::div_t div_nxt;

  always_comb begin
    logic [hdrtm_pkg::DEN_W:0] shifted;
    div_nxt = div_in;
    for (int s = 0; s < hdrtm_pkg::DIV_STEPS; s++) begin
      // remainder stays below the divisor, so the shift needs one extra bit
      shifted = {div_nxt.rem, 1'b0};
      if (shifted >= {1'b0, div_nxt.den}) begin
        shifted = shifted - {1'b0, div_nxt.den};
        div_nxt.quo = {div_nxt.quo[hdrtm_pkg::T_W-2:0], 1'b1};
      end else begin
        div_nxt.quo = {div_nxt.quo[hdrtm_pkg::T_W-2:0], 1'b0};
      end
      div_nxt.rem = shifted[hdrtm_pkg::DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  assign div_out = div_r;

endmodule

// ===== sv/hdrtm_chan.sv =====
// Datapath for one color channel: gain, Reinhard divide, gamma lookup, byte scale.
// Depends on hdrtm_pkg and hdrtm_div_stage.
module hdrtm_chan (
  input  logic                          clk,
  input  logic [hdrtm_pkg::IN_W-1:0]    chan_in,
  input  logic [hdrtm_pkg::GAIN_W-1:0]  gain,
  output logic [hdrtm_pkg::BYTE_W-1:0]  chan_byte
);

  localparam int unsigned PROD_W = hdrtm_pkg::IN_W + hdrtm_pkg::GAIN_W;
  localparam int unsigned A_W    = hdrtm_pkg::Y_W + 12;
  localparam int unsigned V_W    = A_W - hdrtm_pkg::SCALE_SH;
  localparam int unsigned Q5_W   = V_W + 17;

  logic [hdrtm_pkg::IN_W-1:0] in_r;
  logic [hdrtm_pkg::IN_W-1:0] e_r;
  logic [hdrtm_pkg::IN_W-1:0] e_nxt;
  logic [PROD_W-1:0]          prod;

  hdrtm_pkg::div_t div_pipe [hdrtm_pkg::DIV_STAGES+1];

  logic [hdrtm_pkg::Y_W-1:0]    g0_r;
  logic [hdrtm_pkg::Y_W-1:0]    g1_r;
  logic [hdrtm_pkg::FRAC_S-1:0] f_r;
  logic [hdrtm_pkg::GTB-1:0]    k;
  logic [hdrtm_pkg::Y_W-1:0]    y_r;
  logic [hdrtm_pkg::Y_W-1:0]    y_nxt;
  logic [hdrtm_pkg::Y_W+hdrtm_pkg::FRAC_S-1:0] df;
  logic [A_W-1:0]               a_r;
  logic [V_W-1:0]               v;
  logic [Q5_W-1:0]              q5;
  logic [hdrtm_pkg::BYTE_W-1:0] byte_r;

  // saturate the gained value at the top of the input range
  always_comb begin
    prod = PROD_W'(in_r) * PROD_W'(gain);
    if (prod[PROD_W-1:hdrtm_pkg::IN_W+8] != '0) begin
      e_nxt = '1;
    end else begin
      e_nxt = prod[hdrtm_pkg::IN_W+7:8];
    end
  end

  always_ff @(posedge clk) begin
    in_r <= chan_in;
    e_r  <= e_nxt;
  end

  // e * 2^16 / (e + 1.0): upper dividend bits are e itself, lower bits zero
  assign div_pipe[0].rem = hdrtm_pkg::DEN_W'(e_r);
  assign div_pipe[0].den = hdrtm_pkg::DEN_W'(e_r)
                         + hdrtm_pkg::DEN_W'(1 << hdrtm_pkg::IN_FRAC_BITS);
  assign div_pipe[0].quo = '0;

  for (genvar g = 0; g < hdrtm_pkg::DIV_STAGES; g++) begin : g_div
    hdrtm_div_stage u_div (
      .clk     (clk),
      .div_in  (div_pipe[g]),
      .div_out (div_pipe[g+1])
    );
  end

  assign k = div_pipe[hdrtm_pkg::DIV_STAGES].quo[hdrtm_pkg::T_W-1:hdrtm_pkg::FRAC_S];

  always_ff @(posedge clk) begin
    g0_r <= hdrtm_pkg::GAMMA_TAB[hdrtm_pkg::TAB_AW'(k)];
    g1_r <= hdrtm_pkg::GAMMA_TAB[hdrtm_pkg::TAB_AW'(k) + hdrtm_pkg::TAB_AW'(1)];
    f_r  <= div_pipe[hdrtm_pkg::DIV_STAGES].quo[hdrtm_pkg::FRAC_S-1:0];
  end

  // linear interpolation between neighboring table points
  always_comb begin
    df    = (hdrtm_pkg::Y_W + hdrtm_pkg::FRAC_S)'(g1_r - g0_r)
          * (hdrtm_pkg::Y_W + hdrtm_pkg::FRAC_S)'(f_r);
    y_nxt = g0_r + df[hdrtm_pkg::Y_W+hdrtm_pkg::FRAC_S-1:hdrtm_pkg::FRAC_S];
  end

  always_ff @(posedge clk) begin
    y_r <= y_nxt;
    a_r <= A_W'(y_r) * A_W'(hdrtm_pkg::SCALE_MUL);
  end

  // divide by 5 through the reciprocal; exact for this range
  always_comb begin
    v  = a_r[A_W-1:hdrtm_pkg::SCALE_SH];
    q5 = Q5_W'(v) * Q5_W'(hdrtm_pkg::DIV5_MUL);
  end

  always_ff @(posedge clk) begin
    byte_r <= q5[hdrtm_pkg::DIV5_SH+hdrtm_pkg::BYTE_W-1:hdrtm_pkg::DIV5_SH];
  end

  assign chan_byte = byte_r;

endmodule

// ===== sv/hdr_tone_map_gamma_pixel.sv =====
// Top level of the HDR tone mapping pipeline: three channel datapaths and control.
// Depends on hdrtm_pkg and hdrtm_chan.
//
// Usage:
//   Input: drive in_red_in, in_green_in, in_blue_in (unsigned 8.16) and raise start.
//   A pixel item is taken at every clock edge with start high and busy low; busy
//   is always low, so one pixel per clock is sustained with no gaps.
//   Output: out_valid marks out_red_byte, out_green_byte, out_blue_byte for one
//   cycle. The receiver cannot stall; the result must be taken in that cycle.
//   Pipeline: from the accepting edge the pixel passes, in order, the input register,
//   gain multiply, four divider stages of four quotient bits each, table read,
//   interpolation, byte scale multiply and reciprocal divide registers.
//   Config: cfg_data (exposure gain, 8.8) is written on cfg_valid with cfg_ready,
//   which is always high; write it only while no pixel is in flight.
//   Reset (rst_n low, synchronous) clears all valid bits and sets gain to 1.0.
module hdr_tone_map_gamma_pixel (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [hdrtm_pkg::IN_W-1:0]    in_red_in,
  input  logic [hdrtm_pkg::IN_W-1:0]    in_green_in,
  input  logic [hdrtm_pkg::IN_W-1:0]    in_blue_in,
  output logic                          out_valid,
  output logic [hdrtm_pkg::BYTE_W-1:0]  out_red_byte,
  output logic [hdrtm_pkg::BYTE_W-1:0]  out_green_byte,
  output logic [hdrtm_pkg::BYTE_W-1:0]  out_blue_byte,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hdrtm_pkg::GAIN_W-1:0]  cfg_data
);

  logic [hdrtm_pkg::GAIN_W-1:0]  gain_r;
  logic [hdrtm_pkg::LATENCY-1:0] vld_r;
  logic                          accept;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= hdrtm_pkg::GAIN_RESET;
      vld_r  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gain_r <= cfg_data;
      end
      // advance the valid bits alongside the datapath stages
      vld_r <= {vld_r[hdrtm_pkg::LATENCY-2:0], accept};
    end
  end

  assign out_valid = vld_r[hdrtm_pkg::LATENCY-1];

  hdrtm_chan u_red (
    .clk       (clk),
    .chan_in   (in_red_in),
    .gain      (gain_r),
    .chan_byte (out_red_byte)
  );

  hdrtm_chan u_green (
    .clk       (clk),
    .chan_in   (in_green_in),
    .gain      (gain_r),
    .chan_byte (out_green_byte)
  );

  hdrtm_chan u_blue (
    .clk       (clk),
    .chan_in   (in_blue_in),
    .gain      (gain_r),
    .chan_byte (out_blue_byte)
  );

endmodule
